// ===== sv/tacq_pkg.sv =====
// Shared types and codes for the two-class age-ordered queue.
// No dependencies; every file that uses this package refers to it by scoped name.
`default_nettype none

package tacq_pkg;

    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ADD_A    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_B    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_A = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_B = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_OLDEST = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic CLASS_A = 1'b0;
    localparam logic CLASS_B = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  item_value;
    } cmd_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  out_value;
        logic [STATUS_W-1:0] status;
        logic                out_class;
    } rsp_beat_t;

    // per-class request into a chain
    typedef struct packed {
        logic push;
        logic pop;
    } chain_ctl_t;

    // occupancy flags back from a chain
    typedef struct packed {
        logic empty;
        logic full;
    } chain_stat_t;

    // per-cell control
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/tacq_stream_if.sv =====
// Valid/ready stream interface carrying one payload per beat.
// Payload type is supplied by the user, normally from tacq_pkg.
`default_nettype none

interface tacq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/tacq_cell.sv =====
// One storage cell of a class chain: a value and its arrival stamp.
// Depends on tacq_pkg for the cell control struct and value width.
`default_nettype none

module tacq_cell #(
    parameter int unsigned STAMP_BITS = 8
) (
    input  wire logic                          clk,
    input  wire tacq_pkg::cell_ctl_t           ctl,
    input  wire logic [tacq_pkg::VALUE_W-1:0]  push_value,
    input  wire logic [STAMP_BITS-1:0]         push_stamp,
    input  wire logic [tacq_pkg::VALUE_W-1:0]  next_value,
    input  wire logic [STAMP_BITS-1:0]         next_stamp,
    output logic      [tacq_pkg::VALUE_W-1:0]  value,
    output logic      [STAMP_BITS-1:0]         stamp
);

    logic [tacq_pkg::VALUE_W-1:0] value_reg;
    logic [STAMP_BITS-1:0]        stamp_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            value_reg <= next_value;
            stamp_reg <= next_stamp;
        end
        else if (ctl.load)
        begin
            value_reg <= push_value;
            stamp_reg <= push_stamp;
        end
    end

    assign value = value_reg;
    assign stamp = stamp_reg;

endmodule

`default_nettype wire

// ===== sv/tacq_chain.sv =====
// One class FIFO built as a row of cells; the head always sits in cell 0.
// A push loads the first free cell, a pop moves every cell one place down.
// Depends on tacq_pkg and tacq_cell.
`default_nettype none

module tacq_chain #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned STAMP_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tacq_pkg::chain_ctl_t          ctl,
    input  wire logic [tacq_pkg::VALUE_W-1:0]  push_value,
    input  wire logic [STAMP_BITS-1:0]         push_stamp,
    output tacq_pkg::chain_stat_t              stat,
    output logic      [tacq_pkg::VALUE_W-1:0]  head_value,
    output logic      [STAMP_BITS-1:0]         head_stamp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [tacq_pkg::VALUE_W-1:0] cell_value [DEPTH+1];
    logic [STAMP_BITS-1:0]        cell_stamp [DEPTH+1];

    // beyond the tail: shifted into the last cell, never read as live data
    assign cell_value[DEPTH] = '0;
    assign cell_stamp[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tacq_pkg::cell_ctl_t cctl;

        always_comb
        begin
            cctl.shift = ctl.pop;
            cctl.load  = ctl.push && (count_reg == CNT_W'(i));
        end

        tacq_cell #(
            .STAMP_BITS (STAMP_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (cctl),
            .push_value (push_value),
            .push_stamp (push_stamp),
            .next_value (cell_value[i+1]),
            .next_stamp (cell_stamp[i+1]),
            .value      (cell_value[i]),
            .stamp      (cell_stamp[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        stat.empty = (count_reg == '0);
        stat.full  = (count_reg == CNT_W'(DEPTH));
    end

    assign head_value = cell_value[0];
    assign head_stamp = cell_stamp[0];

endmodule

`default_nettype wire

// ===== sv/two_class_age_ordered_queue_core.sv =====
// Two-class age-ordered queue: two cell-chain FIFOs, shared arrival stamp counter.
// Usage:
//   cmd carries one action per beat: add to class A or B, remove the head of
//   class A or B, or remove the older of the two heads (modular stamp
//   comparison, class B wins a tie). Every cmd beat yields exactly one rsp
//   beat with the dequeued value, a status (ok, empty, full) and the class.
//   The response is registered. One cmd beat is taken
//   every cycle while rsp is drained; each per-class chain pops with a
//   single shift of its cells since the head always sits in the first cell.
//   The rsp side is an output register backed by one skid register, so a
//   cmd beat is still taken in the cycle the receiver first stalls; cmd
//   ready drops only once both are full, and order is always kept.
//   Adding to a full class drops the value and reports full; removing from
//   an empty class reports empty and leaves the state alone.
//   Reset (rst_n, asynchronous, active low) empties both classes, zeroes the
//   stamp counter and clears the response registers; no clearing pass.
// Depends on tacq_pkg, tacq_stream_if and tacq_chain.
`default_nettype none

module two_class_age_ordered_queue_core #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned STAMP_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tacq_stream_if.sink   cmd,
    tacq_stream_if.source rsp
);

    tacq_pkg::cmd_beat_t   beat;
    tacq_pkg::chain_ctl_t  ctl_a, ctl_b;
    tacq_pkg::chain_stat_t stat_a, stat_b;
    logic [tacq_pkg::VALUE_W-1:0] head_value_a, head_value_b;
    logic [STAMP_BITS-1:0]        head_stamp_a, head_stamp_b;
    logic [STAMP_BITS-1:0]        stamp_diff;
    logic                         a_older;
    logic                         cmd_fire;
    logic                         pick_a, pick_b;
    tacq_pkg::rsp_beat_t          result;

    logic [STAMP_BITS-1:0] arrival_stamp_reg;
    logic                  rsp_valid_reg;
    tacq_pkg::rsp_beat_t   rsp_reg;
    logic                  skid_valid_reg;
    tacq_pkg::rsp_beat_t   skid_reg;

    assign beat      = cmd.payload;
    assign cmd.ready = !skid_valid_reg;
    assign cmd_fire  = cmd.valid && !skid_valid_reg;

    // head A older when (B - A) mod 2^n is non-zero and below half range
    assign stamp_diff = head_stamp_b - head_stamp_a;
    assign a_older    = (stamp_diff != '0) && !stamp_diff[STAMP_BITS-1];

    always_comb
    begin
        ctl_a         = '0;
        ctl_b         = '0;
        pick_a        = 1'b0;
        pick_b        = 1'b0;
        result        = '0;
        result.status = tacq_pkg::ST_OK;
        unique case (beat.action)
            tacq_pkg::ACT_ADD_A:
            begin
                if (stat_a.full)
                    result.status = tacq_pkg::ST_FULL;
                else
                    ctl_a.push = cmd_fire;
            end
            tacq_pkg::ACT_ADD_B:
            begin
                if (stat_b.full)
                    result.status = tacq_pkg::ST_FULL;
                else
                    ctl_b.push = cmd_fire;
            end
            tacq_pkg::ACT_REMOVE_A:
            begin
                if (stat_a.empty)
                    result.status = tacq_pkg::ST_EMPTY;
                else
                    pick_a = 1'b1;
            end
            tacq_pkg::ACT_REMOVE_B:
            begin
                if (stat_b.empty)
                    result.status = tacq_pkg::ST_EMPTY;
                else
                    pick_b = 1'b1;
            end
            tacq_pkg::ACT_REMOVE_OLDEST:
            begin
                if (stat_a.empty && stat_b.empty)
                    result.status = tacq_pkg::ST_EMPTY;
                else if (stat_b.empty)
                    pick_a = 1'b1;
                else if (stat_a.empty)
                    pick_b = 1'b1;
                else if (a_older)
                    pick_a = 1'b1;
                else
                    pick_b = 1'b1;
            end
            default:
            begin
                result.status = tacq_pkg::ST_OK;
            end
        endcase

        ctl_a.pop = pick_a && cmd_fire;
        ctl_b.pop = pick_b && cmd_fire;
        if (pick_a)
        begin
            result.out_value = head_value_a;
            result.out_class = tacq_pkg::CLASS_A;
        end
        else if (pick_b)
        begin
            result.out_value = head_value_b;
            result.out_class = tacq_pkg::CLASS_B;
        end
    end

    tacq_chain #(
        .DEPTH      (DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_chain_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_a),
        .push_value (beat.item_value),
        .push_stamp (arrival_stamp_reg),
        .stat       (stat_a),
        .head_value (head_value_a),
        .head_stamp (head_stamp_a)
    );

    tacq_chain #(
        .DEPTH      (DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_chain_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_b),
        .push_value (beat.item_value),
        .push_stamp (arrival_stamp_reg),
        .stat       (stat_b),
        .head_value (head_value_b),
        .head_stamp (head_stamp_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrival_stamp_reg <= '0;
        end
        else if (ctl_a.push || ctl_b.push)
        begin
            arrival_stamp_reg <= arrival_stamp_reg + STAMP_BITS'(1);
        end
    end

    // output register with a one-beat skid behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            rsp_reg        <= '0;
            skid_reg       <= '0;
        end
        else if (!rsp_valid_reg || rsp.ready)
        begin
            if (skid_valid_reg)
            begin
                rsp_valid_reg  <= 1'b1;
                rsp_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                rsp_valid_reg <= cmd_fire;
                if (cmd_fire)
                    rsp_reg <= result;
            end
        end
        else if (cmd_fire)
        begin
            skid_valid_reg <= 1'b1;
            skid_reg       <= result;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

endmodule

`default_nettype wire

// ===== test/tb_two_class_age_ordered_queue_core.sv =====
// Testbench for two_class_age_ordered_queue_core: random cmd/rsp stalls, in-line queue model.
// Needs tacq_pkg, tacq_stream_if and the core from the RTL tree; reads nothing else.
`default_nettype none

module tb_two_class_age_ordered_queue_core;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned STAMP_BITS = 8;
    localparam int unsigned CMD_TARGET = 1650;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned MAX_REPORTS = 50;
    localparam int unsigned VALUE_W    = tacq_pkg::VALUE_W;
    localparam int unsigned ACTION_W   = tacq_pkg::ACTION_W;

    // codes five to seven are not decoded by the core
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;

    typedef struct {
        logic                hold;
        tacq_pkg::cmd_beat_t beat;
    } backlog_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tacq_stream_if #(.payload_t(tacq_pkg::cmd_beat_t)) cmd_if ();
    tacq_stream_if #(.payload_t(tacq_pkg::rsp_beat_t)) rsp_if ();

    two_class_age_ordered_queue_core #(
        .DEPTH      (DEPTH),
        .STAMP_BITS (STAMP_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model of both classes, indexed by class (0 A, 1 B)
    logic [VALUE_W-1:0]    cls_value [2][DEPTH];
    logic [STAMP_BITS-1:0] cls_stamp [2][DEPTH];
    int unsigned           cls_head  [2];
    int unsigned           cls_count [2];
    logic [STAMP_BITS-1:0] stamp_next;

    backlog_entry_t      cmd_backlog[$];
    backlog_entry_t      next_entry;
    tacq_pkg::rsp_beat_t due_results[$];
    tacq_pkg::rsp_beat_t want_rsp;
    tacq_pkg::rsp_beat_t got_rsp;

    int unsigned cmd_total;
    int unsigned beats_issued;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    logic        all_returned;

    function automatic tacq_pkg::rsp_beat_t queue_model_step(input tacq_pkg::cmd_beat_t c);
        tacq_pkg::rsp_beat_t   r;
        int                    pick;
        int                    cls;
        int unsigned           slot;
        logic [STAMP_BITS-1:0] gap;
        r = '0;
        pick = -1;
        case (c.action)
            tacq_pkg::ACT_ADD_A, tacq_pkg::ACT_ADD_B:
            begin
                cls = (c.action == tacq_pkg::ACT_ADD_B) ? 1 : 0;
                if (cls_count[cls] == DEPTH)
                    r.status = tacq_pkg::ST_FULL;
                else
                begin
                    slot = (cls_head[cls] + cls_count[cls]) % DEPTH;
                    cls_value[cls][slot] = c.item_value;
                    cls_stamp[cls][slot] = stamp_next;
                    cls_count[cls]++;
                    stamp_next = stamp_next + STAMP_BITS'(1);
                end
            end
            tacq_pkg::ACT_REMOVE_A:
                if (cls_count[0] == 0) r.status = tacq_pkg::ST_EMPTY; else pick = 0;
            tacq_pkg::ACT_REMOVE_B:
                if (cls_count[1] == 0) r.status = tacq_pkg::ST_EMPTY; else pick = 1;
            tacq_pkg::ACT_REMOVE_OLDEST:
            begin
                if (cls_count[0] == 0 && cls_count[1] == 0)
                    r.status = tacq_pkg::ST_EMPTY;
                else if (cls_count[1] == 0)
                    pick = 0;
                else if (cls_count[0] == 0)
                    pick = 1;
                else
                begin
                    // A is older only if B's stamp is ahead by less than half the range
                    gap = cls_stamp[1][cls_head[1]] - cls_stamp[0][cls_head[0]];
                    pick = (gap != 0 && gap < (1 << (STAMP_BITS - 1))) ? 0 : 1;
                end
            end
            default: ;
        endcase
        if (pick >= 0)
        begin
            r.out_value = cls_value[pick][cls_head[pick]];
            r.out_class = (pick == 1) ? tacq_pkg::CLASS_B : tacq_pkg::CLASS_A;
            cls_head[pick] = (cls_head[pick] + 1) % DEPTH;
            cls_count[pick]--;
        end
        return r;
    endfunction

    function automatic int idle_pct(input bit sender);
        int unsigned third;
        if (cmd_total == 0)
            return 0;
        third = beats_issued * 3 / cmd_total;
        if (third == 0)
            return sender ? 37 : 49;
        if (third == 1)
            return sender ? 49 : 37;
        return 0;
    endfunction

    task automatic queue_cmd(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
        backlog_entry_t e;
        e.hold = 1'b0;
        e.beat.action = act;
        e.beat.item_value = val;
        cmd_backlog.push_back(e);
        cmd_total++;
    endtask

    // sender holds off until every outstanding response has come back
    task automatic queue_pause();
        backlog_entry_t e;
        e.hold = 1'b1;
        e.beat = '0;
        cmd_backlog.push_back(e);
    endtask

    task automatic queue_remove_run(input logic [ACTION_W-1:0] act, input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_cmd(act, VALUE_W'($urandom));
    endtask

    // empty one class, overfill it, then empty it past the bottom
    task automatic queue_fill_cycle(input logic [ACTION_W-1:0] add_act,
                                    input logic [ACTION_W-1:0] rem_act);
        queue_remove_run(rem_act, DEPTH + 1);
        queue_remove_run(add_act, DEPTH + 2);
        queue_remove_run(rem_act, DEPTH + 1);
    endtask

    // wrap the stamp counter so both heads carry the same stamp; B must win
    task automatic queue_stamp_tie();
        queue_remove_run(tacq_pkg::ACT_REMOVE_A, DEPTH + 1);
        queue_remove_run(tacq_pkg::ACT_REMOVE_B, DEPTH + 1);
        queue_cmd(tacq_pkg::ACT_ADD_A, VALUE_W'($urandom));
        for (int unsigned i = 0; i < (1 << STAMP_BITS) - 1; i++)
        begin
            queue_cmd(tacq_pkg::ACT_ADD_B, VALUE_W'($urandom));
            queue_cmd(tacq_pkg::ACT_REMOVE_B, VALUE_W'($urandom));
        end
        queue_cmd(tacq_pkg::ACT_ADD_B, VALUE_W'($urandom));
        queue_remove_run(tacq_pkg::ACT_REMOVE_OLDEST, 3);
    endtask

    function automatic logic [ACTION_W-1:0] random_action(input int unsigned add_pct);
        int unsigned            roll;
        logic [ACTION_W-1:0]    act;
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            act = ACT_UNUSED_FIRST + ACTION_W'($urandom_range(2));
            return act;
        end
        if (roll < 4 + add_pct)
            return $urandom_range(1) ? tacq_pkg::ACT_ADD_B : tacq_pkg::ACT_ADD_A;
        case ($urandom_range(3))
            0:       return tacq_pkg::ACT_REMOVE_A;
            1:       return tacq_pkg::ACT_REMOVE_B;
            default: return tacq_pkg::ACT_REMOVE_OLDEST;
        endcase
    endfunction

    task automatic queue_random_bursts(input int unsigned upto);
        int unsigned add_pct;
        int unsigned len;
        while (cmd_total < upto)
        begin
            case ($urandom_range(2))
                0:       add_pct = 20;
                1:       add_pct = 48;
                default: add_pct = 76;
            endcase
            len = $urandom_range(60, 15);
            for (int unsigned i = 0; i < len; i++)
                queue_cmd(random_action(add_pct), VALUE_W'($urandom));
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n && (!cmd_if.valid || cmd_if.ready))
        begin
            if (cmd_backlog.size() != 0 && cmd_backlog[0].hold)
            begin
                cmd_if.valid <= 1'b0;
                if (all_returned && !cmd_if.valid)
                    void'(cmd_backlog.pop_front());
            end
            else if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b1))
            begin
                next_entry = cmd_backlog.pop_front();
                cmd_if.valid <= 1'b1;
                cmd_if.payload <= next_entry.beat;
                beats_issued <= beats_issued + 1;
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
        rsp_if.ready <= ($urandom_range(99) >= idle_pct(1'b0));

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // model update on each cmd beat, compare on each rsp beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
                due_results.push_back(queue_model_step(cmd_if.payload));
            if (rsp_if.valid && rsp_if.ready)
            begin
                got_rsp = rsp_if.payload;
                if (due_results.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected rsp beat, expected none actual %0h",
                                 $time, got_rsp);
                    fail_count++;
                end
                else
                begin
                    want_rsp = due_results.pop_front();
                    check_field("out_value", want_rsp.out_value, got_rsp.out_value);
                    check_field("status", want_rsp.status, got_rsp.status);
                    check_field("out_class", want_rsp.out_class, got_rsp.out_class);
                end
            end
            all_returned <= (due_results.size() == 0);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("** two_class_age_ordered_queue_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        cmd_if.valid = 1'b0;
        cmd_if.payload = '0;
        rsp_if.ready = 1'b0;
        for (int c = 0; c < 2; c++)
        begin
            cls_head[c] = 0;
            cls_count[c] = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                cls_value[c][i] = '0;
                cls_stamp[c][i] = '0;
            end
        end
        stamp_next = '0;
        cmd_total = 0;
        beats_issued = 0;
        fail_count = 0;
        quiet_cycles = 0;
        all_returned = 1'b1;

        // directed: empty removes, unused codes, ordering between the heads
        queue_cmd(tacq_pkg::ACT_REMOVE_A, 8'hFF);
        queue_cmd(tacq_pkg::ACT_REMOVE_B, 8'h00);
        queue_cmd(tacq_pkg::ACT_REMOVE_OLDEST, 8'h5A);
        for (int k = 0; k < 3; k++)
            queue_cmd(ACT_UNUSED_FIRST + k[ACTION_W-1:0], (k == 1) ? 8'h00 : 8'hFF);
        queue_cmd(tacq_pkg::ACT_ADD_A, 8'h00);
        queue_cmd(tacq_pkg::ACT_ADD_B, 8'hFF);
        queue_cmd(tacq_pkg::ACT_ADD_A, 8'h55);
        queue_cmd(tacq_pkg::ACT_ADD_B, 8'hAA);
        queue_cmd(tacq_pkg::ACT_REMOVE_OLDEST, 8'h00);   // A head older
        queue_cmd(tacq_pkg::ACT_REMOVE_OLDEST, 8'h00);   // B head older
        queue_cmd(tacq_pkg::ACT_REMOVE_B, 8'h00);
        queue_cmd(tacq_pkg::ACT_REMOVE_OLDEST, 8'h00);   // only A left
        queue_cmd(tacq_pkg::ACT_ADD_B, 8'h01);
        queue_cmd(tacq_pkg::ACT_REMOVE_OLDEST, 8'hFE);   // only B left
        queue_cmd(tacq_pkg::ACT_REMOVE_OLDEST, 8'h80);   // both empty
        queue_cmd(tacq_pkg::ACT_REMOVE_B, 8'h7F);
        queue_pause();

        queue_fill_cycle(tacq_pkg::ACT_ADD_A, tacq_pkg::ACT_REMOVE_A);
        queue_fill_cycle(tacq_pkg::ACT_ADD_B, tacq_pkg::ACT_REMOVE_B);
        queue_random_bursts(cmd_total + 300);
        queue_stamp_tie();
        queue_pause();
        queue_random_bursts(cmd_total + 350);
        queue_pause();
        queue_random_bursts(CMD_TARGET);

        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_if.valid || due_results.size() != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && due_results.size() == 0)
            $display("** two_class_age_ordered_queue_core: PASSED **");
        else
            $display("** two_class_age_ordered_queue_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
